// ===== hdl/pgc_pkg.sv =====
package pgc_pkg;

    // item kinds carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_PULSE = 2'd0,
        FUNC_PPS   = 2'd1,
        FUNC_ADDR  = 2'd2,
        FUNC_READ  = 2'd3
    } t_func;

    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned POS_W      = 7;
    localparam int unsigned SNAP_DEPTH = 4;
    localparam int unsigned SNAP_IDX_W = $clog2(SNAP_DEPTH);

    // one accepted input transaction
    typedef struct packed {
        t_func              func;
        logic [BYTE_W-1:0]  bus_byte;
        logic [POS_W-1:0]   read_position;
    } t_item;

endpackage

// ===== hdl/pps_gated_counter_with_bus_readout.sv =====
// pps gated pulse counter with a byte-wide bus readout
//
// input channel (s side): one transaction per event. tuser carries the kind:
// counted pulse, pps edge, bus address write or bus read byte. tdata carries
// bus_byte (address for an address write) and read_position (byte index of
// a read transfer, zero for the first byte).
// output channel (m side): one transaction per bus read byte, carrying the
// returned data byte; pulses, pps edges and address writes give nothing.
//
// latency: a read byte is registered and appears on the output in the cycle after acceptance.
// throughput: one transaction per cycle while the output is taken, set by the single output register;
// the state (counter, latch, pointer, snapshot) updates at acceptance.
// when the receiver stalls with a byte held, the input stays ready only if
// the held byte is taken in the same cycle, so nothing is dropped or repeated.
//
// reset (synchronous, active low) clears the counter, the latched count, the
// pointer, the snapshot bytes and the output valid; no clearing pass needed.
module pps_gated_counter_with_bus_readout
    import pgc_pkg::*;
#(
    parameter int unsigned READ_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] bus_byte, [14:8] read_position, [15] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] func
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // [7:0] read_data
);

    // readable positions limited by both the parameter and the snapshot depth
    localparam int unsigned READ_LIMIT_INT =
        (READ_BYTES < SNAP_DEPTH) ? READ_BYTES : SNAP_DEPTH;
    localparam logic [BYTE_W-1:0] READ_LIMIT = BYTE_W'(READ_LIMIT_INT);

    t_item              item;
    logic               accept;
    logic [COUNT_W-1:0] latched_count;
    logic [BYTE_W-1:0]  read_data;

    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_read_data;
    logic               n_out_valid;

    assign item.func          = t_func'(i_s_tuser);
    assign item.bus_byte      = i_s_tdata[7:0];
    assign item.read_position = i_s_tdata[14:8];

    // ready while the output register is empty or being emptied this cycle
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    pgc_counter u_counter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (accept),
        .i_item          (item),
        .o_latched_count (latched_count)
    );

    pgc_readout #(
        .READ_LIMIT (READ_LIMIT)
    ) u_readout (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (accept),
        .i_item          (item),
        .i_latched_count (latched_count),
        .o_read_data     (read_data)
    );

    // output register: loads on a read transaction, drains when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        if (accept && (item.func == FUNC_READ)) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (item.func == FUNC_READ)) begin
            r_read_data <= read_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_read_data;

endmodule

// ===== hdl/pgc_counter.sv =====
module pgc_counter
    import pgc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_item              i_item,
    output logic [COUNT_W-1:0] o_latched_count
);

    logic [COUNT_W-1:0] r_pulse_counter;
    logic [COUNT_W-1:0] r_latched_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_counter <= '0;
            r_latched_count <= '0;
        end else if (i_valid) begin
            case (i_item.func)
                FUNC_PULSE: begin
                    r_pulse_counter <= r_pulse_counter + COUNT_W'(1);
                end
                FUNC_PPS: begin
                    r_latched_count <= r_pulse_counter;
                    r_pulse_counter <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_latched_count = r_latched_count;

endmodule

// ===== hdl/pgc_readout.sv =====
module pgc_readout
    import pgc_pkg::*;
#(
    parameter logic [BYTE_W-1:0] READ_LIMIT = 8'd4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_item              i_item,
    input  logic [COUNT_W-1:0] i_latched_count,
    output logic [BYTE_W-1:0]  o_read_data
);

    logic [BYTE_W-1:0] r_register_pointer;
    logic [BYTE_W-1:0] r_snapshot [SNAP_DEPTH];

    logic              first_byte;
    logic              refresh;
    logic [BYTE_W-1:0] index;
    logic              in_range;

    assign first_byte = (i_item.read_position == '0);
    assign refresh    = first_byte && (r_register_pointer == '0);
    assign index      = first_byte ? r_register_pointer : BYTE_W'(i_item.read_position);
    assign in_range   = (index < BYTE_W'(SNAP_DEPTH)) && (index < READ_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_register_pointer <= '0;
            for (int i = 0; i < SNAP_DEPTH; i++) begin
                r_snapshot[i] <= '0;
            end
        end else if (i_valid) begin
            if (i_item.func == FUNC_ADDR) begin
                r_register_pointer <= i_item.bus_byte;
            end
            if ((i_item.func == FUNC_READ) && refresh) begin
                for (int i = 0; i < SNAP_DEPTH; i++) begin
                    r_snapshot[i] <= i_latched_count[i*BYTE_W +: BYTE_W];
                end
            end
        end
    end

    // the refreshing read sees the new snapshot byte 0 straight from the latch
    always_comb begin
        if (!in_range) begin
            o_read_data = '0;
        end else if (refresh) begin
            o_read_data = i_latched_count[BYTE_W-1:0];
        end else begin
            o_read_data = r_snapshot[index[SNAP_IDX_W-1:0]];
        end
    end

endmodule
